// ===== rtl/sbrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbrc_pkg
// Shared types, constants and helpers of the 16-bit eight-register core.
// ----------------------------------------------------------------------------
package sbrc_pkg;

  localparam int unsigned MemWordsDef = 8192;
  localparam int unsigned AddrW       = 13;
  localparam int unsigned DataW       = 16;
  localparam int unsigned RegIdxW     = 3;
  localparam int unsigned NumRegs     = 8;

  localparam logic [RegIdxW-1:0] LinkReg = 3'd7;

  // function codes of the register-register group
  localparam logic [3:0] FnAdd = 4'd0;
  localparam logic [3:0] FnSub = 4'd1;
  localparam logic [3:0] FnOr  = 4'd2;
  localparam logic [3:0] FnAnd = 4'd3;
  localparam logic [3:0] FnSlt = 4'd4;
  localparam logic [3:0] FnJr  = 4'd8;

  typedef enum logic [2:0] {
    OP_ALU  = 3'd0,
    OP_ADDI = 3'd1,
    OP_J    = 3'd2,
    OP_JAL  = 3'd3,
    OP_LW   = 3'd4,
    OP_SW   = 3'd5,
    OP_JEQ  = 3'd6,
    OP_SLTI = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_MEM,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic [DataW-1:0]   pc;
    logic               halted;
    logic               rwe;
    logic [RegIdxW-1:0] rwi;
    logic [DataW-1:0]   rwv;
    logic               mwe;
    logic [AddrW-1:0]   mwa;
    logic [DataW-1:0]   mwd;
  } result_t;

  function automatic logic [DataW-1:0] sext7(input logic [6:0] v);
    return {{(DataW-7){v[6]}}, v};
  endfunction

endpackage : sbrc_pkg
`default_nettype wire

// ===== rtl/sbrc_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbrc_mem
// Unified single-port word memory with registered read and a clearing sweep
// that zeroes every word after reset.
// ----------------------------------------------------------------------------
module sbrc_mem #(
  parameter int unsigned MEM_WORDS = sbrc_pkg::MemWordsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sbrc_pkg::mem_req_t      req_i,
  output logic [sbrc_pkg::DataW-1:0] rdata_o,
  output logic                    clr_busy_o
);
  import sbrc_pkg::*;

  // MEM_WORDS is a power of two
  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [DataW-1:0] mem_q [MEM_WORDS];
  logic [DataW-1:0] rdata_q;
  logic [AW:0]      clr_cnt_q, clr_cnt_d;
  logic             busy;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [DataW-1:0] wr_data;

  assign busy      = !clr_cnt_q[AW];
  assign clr_cnt_d = busy ? clr_cnt_q + 1'b1 : clr_cnt_q;

  assign wr_en   = busy || req_i.wr;
  assign wr_addr = busy ? clr_cnt_q[AW-1:0] : req_i.addr[AW-1:0];
  assign wr_data = busy ? '0 : req_i.wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[req_i.addr[AW-1:0]];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = busy;

endmodule : sbrc_mem
`default_nettype wire

// ===== rtl/sbrc_rf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbrc_rf
// Eight-entry register file, two registered read ports, one write port.
// Entries never written read as zero; entry 0 is never written.
// ----------------------------------------------------------------------------
module sbrc_rf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [sbrc_pkg::RegIdxW-1:0] rd_idx_a_i,
  input  logic [sbrc_pkg::RegIdxW-1:0] rd_idx_b_i,
  input  sbrc_pkg::rf_wr_t             wr_i,
  output logic [sbrc_pkg::DataW-1:0]   rdata_a_o,
  output logic [sbrc_pkg::DataW-1:0]   rdata_b_o
);
  import sbrc_pkg::*;

  logic [DataW-1:0]   regs_q [NumRegs];
  logic [NumRegs-1:0] valid_q;
  logic [DataW-1:0]   rdata_a_q, rdata_b_q;
  logic               wr_ok;

  assign wr_ok = wr_i.en && (wr_i.idx != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_ok) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      regs_q[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_a_q <= valid_q[rd_idx_a_i] ? regs_q[rd_idx_a_i] : '0;
      rdata_b_q <= valid_q[rd_idx_b_i] ? regs_q[rd_idx_b_i] : '0;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule : sbrc_rf
`default_nettype wire

// ===== rtl/sixteen_bit_risc_core_step_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sixteen_bit_risc_core_step_core
// 16-bit eight-register processor with one unified word memory, driven one
// request at a time.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o): req_type_i = 0 writes load_data_i
//    to memory word load_addr_i (wrapped to MEM_WORDS); req_type_i = 1 fetches
//    and executes the instruction at the program counter.
//  - Output channel (out_valid_o/out_ready_i): exactly one result per request,
//    giving pc, halt flag and any register or memory write it made.
//  - Steps per request: memory word fetch, register read, execute, plus a second
//    memory access for lw; a load only writes its word and reports.
//    One memory port carries fetch, data access and loads, so requests are
//    taken one at a time; a new request is taken once the last has moved its
//    result into the output register.
//  - Reset: pc, halt flag and registers clear at once; memory is cleared by a
//    sweep over all MEM_WORDS words, during which in_ready_o stays low.
//  - Receiver stall: the result waits in the output register; a following
//    request is still accepted and runs up to its commit, where it waits for
//    the output register to empty. A step writes nothing until that point; a
//    load writes its memory word as it is accepted.
//  - A j to its own address halts; later steps report the pc and halted only.
// ----------------------------------------------------------------------------
module sixteen_bit_risc_core_step_core #(
  parameter int unsigned MEM_WORDS = sbrc_pkg::MemWordsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [sbrc_pkg::AddrW-1:0]   load_addr_i,
  input  logic [sbrc_pkg::DataW-1:0]   load_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sbrc_pkg::DataW-1:0]   prog_counter_o,
  output logic                         halted_o,
  output logic                         reg_wr_en_o,
  output logic [sbrc_pkg::RegIdxW-1:0] reg_wr_index_o,
  output logic [sbrc_pkg::DataW-1:0]   reg_wr_value_o,
  output logic                         mem_wr_en_o,
  output logic [sbrc_pkg::AddrW-1:0]   mem_wr_addr_o,
  output logic [sbrc_pkg::DataW-1:0]   mem_wr_data_o
);
  import sbrc_pkg::*;

  // word address mask, MEM_WORDS being a power of two
  localparam logic [AddrW-1:0] AddrMask = AddrW'(MEM_WORDS - 1);

  // --- state --------------------------------------------------------------
  state_e           state_q, state_d;
  logic [DataW-1:0] pc_q;
  logic             halted_q;
  logic [DataW-1:0] instr_q;

  // pending report for loads and halted steps
  logic             rep_mwe_q;
  logic [AddrW-1:0] rep_mwa_q;
  logic [DataW-1:0] rep_mwd_q;

  // output register
  logic    out_valid_q;
  result_t out_q, out_d;
  logic    out_load;

  // --- handshake ----------------------------------------------------------
  logic in_acc;
  logic slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // --- memory and register file ------------------------------------------
  mem_req_t         mem_req;
  logic [DataW-1:0] mem_rdata;
  logic             mem_busy;

  rf_wr_t           rf_wr;
  logic             rf_rd_en;
  logic [DataW-1:0] va, vb;

  sbrc_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rdata_o    (mem_rdata),
    .clr_busy_o (mem_busy)
  );

  // register indices are taken straight from the fetched word
  assign rf_rd_en = (state_q == ST_DECODE);

  sbrc_rf u_rf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rf_rd_en),
    .rd_idx_a_i (mem_rdata[12:10]),
    .rd_idx_b_i (mem_rdata[9:7]),
    .wr_i       (rf_wr),
    .rdata_a_o  (va),
    .rdata_b_o  (vb)
  );

  // --- execute datapath ---------------------------------------------------
  opcode_e            op;
  logic [RegIdxW-1:0] rb, rc;
  logic [3:0]         fn;
  logic [DataW-1:0]   imm, tgt, next_pc, daddr;
  logic               ex_wr;
  logic [RegIdxW-1:0] ex_wi;
  logic [DataW-1:0]   ex_wv;
  logic [DataW-1:0]   ex_pc;
  logic               ex_halt;
  logic               ex_lw;
  logic               ex_sw;
  logic               ex_rwe;

  assign op      = opcode_e'(instr_q[15:13]);
  assign rb      = instr_q[9:7];
  assign rc      = instr_q[6:4];
  assign fn      = instr_q[3:0];
  assign imm     = sext7(instr_q[6:0]);
  assign tgt     = {{(DataW-AddrW){1'b0}}, instr_q[AddrW-1:0]};
  assign next_pc = pc_q + 16'd1;
  assign daddr   = va + imm;

  always_comb begin
    ex_wr   = 1'b0;
    ex_wi   = '0;
    ex_wv   = '0;
    ex_pc   = pc_q;
    ex_halt = 1'b0;
    ex_lw   = 1'b0;
    ex_sw   = 1'b0;
    case (op)
      OP_ALU: begin
        case (fn)
          FnAdd: begin ex_wr = 1'b1; ex_wi = rc; ex_wv = va + vb; ex_pc = next_pc; end
          FnSub: begin ex_wr = 1'b1; ex_wi = rc; ex_wv = va - vb; ex_pc = next_pc; end
          FnOr:  begin ex_wr = 1'b1; ex_wi = rc; ex_wv = va | vb; ex_pc = next_pc; end
          FnAnd: begin ex_wr = 1'b1; ex_wi = rc; ex_wv = va & vb; ex_pc = next_pc; end
          FnSlt: begin
            ex_wr = 1'b1;
            ex_wi = rc;
            ex_wv = {15'd0, va < vb};
            ex_pc = next_pc;
          end
          FnJr:    ex_pc = va;
          default: ;  // unlisted code: no effect, pc holds
        endcase
      end
      OP_ADDI: begin ex_wr = 1'b1; ex_wi = rb; ex_wv = va + imm; ex_pc = next_pc; end
      OP_J: begin
        // jump to itself halts
        if (pc_q == tgt) ex_halt = 1'b1;
        else             ex_pc   = tgt;
      end
      OP_JAL: begin ex_wr = 1'b1; ex_wi = LinkReg; ex_wv = next_pc; ex_pc = tgt; end
      OP_LW:  begin ex_lw = 1'b1; ex_pc = next_pc; end
      OP_SW:  begin ex_sw = 1'b1; ex_pc = next_pc; end
      OP_JEQ: ex_pc = (va == vb) ? next_pc + imm : next_pc;
      OP_SLTI: begin
        ex_wr = 1'b1;
        ex_wi = rb;
        ex_wv = {15'd0, va < imm};
        ex_pc = next_pc;
      end
      default: ;
    endcase
  end

  assign ex_rwe = ex_wr && (ex_wi != '0);

  // --- next state ---------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (!mem_busy) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (!req_type_i || halted_q) ? ST_REPORT : ST_DECODE;
        end
      end
      ST_DECODE: state_d = ST_EXEC;
      ST_EXEC: begin
        if (slot_free) state_d = ex_lw ? ST_MEM : ST_IDLE;
      end
      ST_MEM:    if (slot_free) state_d = ST_IDLE;
      ST_REPORT: if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // --- control outputs ----------------------------------------------------
  always_comb begin
    mem_req  = '0;
    rf_wr    = '0;
    out_load = 1'b0;
    out_d    = '0;
    out_d.pc     = pc_q;
    out_d.halted = halted_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!req_type_i) begin
            mem_req.wr    = 1'b1;
            mem_req.addr  = load_addr_i;
            mem_req.wdata = load_data_i;
          end else if (!halted_q) begin
            mem_req.rd   = 1'b1;
            mem_req.addr = pc_q[AddrW-1:0];
          end
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          if (ex_lw) begin
            mem_req.rd   = 1'b1;
            mem_req.addr = daddr[AddrW-1:0];
          end else begin
            mem_req.wr    = ex_sw;
            mem_req.addr  = daddr[AddrW-1:0];
            mem_req.wdata = vb;
            rf_wr.en      = ex_rwe;
            rf_wr.idx     = ex_wi;
            rf_wr.data    = ex_wv;
            out_load      = 1'b1;
            out_d.pc      = ex_pc;
            out_d.halted  = halted_q || ex_halt;
            out_d.rwe     = ex_rwe;
            out_d.rwi     = ex_rwe ? ex_wi : '0;
            out_d.rwv     = ex_rwe ? ex_wv : '0;
            out_d.mwe     = ex_sw;
            out_d.mwa     = ex_sw ? (daddr[AddrW-1:0] & AddrMask) : '0;
            out_d.mwd     = ex_sw ? vb : '0;
          end
        end
      end
      ST_MEM: begin
        if (slot_free) begin
          rf_wr.en   = (rb != '0);
          rf_wr.idx  = rb;
          rf_wr.data = mem_rdata;
          out_load   = 1'b1;
          out_d.pc   = ex_pc;
          out_d.rwe  = (rb != '0);
          out_d.rwi  = (rb != '0) ? rb : '0;
          out_d.rwv  = (rb != '0) ? mem_rdata : '0;
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          out_d.mwe = rep_mwe_q;
          out_d.mwa = rep_mwa_q;
          out_d.mwd = rep_mwd_q;
        end
      end
      default: ;
    endcase
  end

  // --- registers ----------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pc_q        <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        pc_q     <= out_d.pc;
        halted_q <= out_d.halted;
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECODE) begin
      instr_q <= mem_rdata;
    end
    if (in_acc) begin
      rep_mwe_q <= !req_type_i;
      rep_mwa_q <= req_type_i ? '0 : (load_addr_i & AddrMask);
      rep_mwd_q <= req_type_i ? '0 : load_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign prog_counter_o = out_q.pc;
  assign halted_o       = out_q.halted;
  assign reg_wr_en_o    = out_q.rwe;
  assign reg_wr_index_o = out_q.rwi;
  assign reg_wr_value_o = out_q.rwv;
  assign mem_wr_en_o    = out_q.mwe;
  assign mem_wr_addr_o  = out_q.mwa;
  assign mem_wr_data_o  = out_q.mwd;

  // --- assertions ---------------------------------------------------------
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag dropped");

  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.en |-> (rf_wr.idx != '0))
    else $error("write to register zero");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> (state_q == ST_CLEAR) && !mem_req.rd && !mem_req.wr)
    else $error("memory access during clearing sweep");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_valid_q) |-> out_ready_i)
    else $error("result overwritten before taken");

  a_step_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_type_i && !halted_q) |=> (state_q == ST_DECODE) && !mem_busy)
    else $error("accepted step did not fetch");

endmodule : sixteen_bit_risc_core_step_core
`default_nettype wire

// ===== sim/sixteen_bit_risc_core_step_core_tb.sv =====
// ----------------------------------------------------------------------------
// sixteen_bit_risc_core_step_core_tb
// Self-checking bench for the 16-bit eight-register core. It loads short
// programs through the request channel and steps them one instruction at a
// time. A scoreboard class keeps its own copy of pc, halt flag, register file
// and memory. From that copy it works out the report of every accepted request
// and checks each field of the reports that come back, in order.
// ----------------------------------------------------------------------------
module sixteen_bit_risc_core_step_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbrc_pkg::*;

  localparam int unsigned MemWords   = MemWordsDef;
  localparam int          RandomReqs = 1200;
  localparam int          PauseAt    = 600;   // sender waits for a full drain here
  localparam int          HoldAt     = 400;   // receiver's long hold-off starts here
  localparam int          HoldCycles = 120;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow core state plus the queue of reports still owed
  // --------------------------------------------------------------------------
  class core_scoreboard;
    logic [DataW-1:0] pc;
    bit               halt;
    logic [DataW-1:0] regs [NumRegs];
    logic [DataW-1:0] mem  [MemWords];
    result_t          report_q [$];
    int               errors;
    int               n_checked;
    int               n_loads;
    int               n_steps;

    function new();
      pc   = '0;
      halt = 1'b0;
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      errors    = 0;
      n_checked = 0;
      n_loads   = 0;
      n_steps   = 0;
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    // Runs one accepted request against the shadow state and queues its report.
    function void note_request(bit rtype, logic [AddrW-1:0] laddr, logic [DataW-1:0] ldata);
      result_t          r;
      int unsigned      a;
      logic [DataW-1:0] ins, imm, tgt, va, vb, nxt, wv, ea;
      opcode_e          op;
      logic [2:0]       ra, rb, rc, wi;
      logic [3:0]       fn;
      bit               wr;
      r  = '0;
      wr = 1'b0;
      wi = '0;
      wv = '0;
      if (!rtype) begin
        n_loads++;
        a      = laddr % MemWords;
        mem[a] = ldata;
        r.mwe  = 1'b1;
        r.mwa  = AddrW'(a);
        r.mwd  = ldata;
      end else begin
        n_steps++;
        if (!halt) begin
          ins = mem[pc % MemWords];
          op  = opcode_e'(ins[15:13]);
          ra  = ins[12:10];
          rb  = ins[9:7];
          rc  = ins[6:4];
          fn  = ins[3:0];
          imm = {{9{ins[6]}}, ins[6:0]};
          tgt = {3'b000, ins[12:0]};
          va  = regs[ra];
          vb  = regs[rb];
          nxt = pc + 16'd1;
          case (op)
            OP_ALU: begin
              case (fn)
                FnAdd: begin wr = 1; wi = rc; wv = va + vb; pc = nxt; end
                FnSub: begin wr = 1; wi = rc; wv = va - vb; pc = nxt; end
                FnOr:  begin wr = 1; wi = rc; wv = va | vb; pc = nxt; end
                FnAnd: begin wr = 1; wi = rc; wv = va & vb; pc = nxt; end
                FnSlt: begin wr = 1; wi = rc; wv = (va < vb) ? 16'd1 : 16'd0; pc = nxt; end
                FnJr:  pc = va;
                default: ;  // unknown function: nothing moves
              endcase
            end
            OP_ADDI: begin wr = 1; wi = rb; wv = va + imm; pc = nxt; end
            OP_J: begin
              // halts only when the full 16-bit pc matches the 13-bit target
              if (pc == tgt) halt = 1'b1;
              else pc = tgt;
            end
            OP_JAL: begin wr = 1; wi = LinkReg; wv = nxt; pc = tgt; end
            OP_LW: begin
              ea = va + imm;
              wr = 1; wi = rb; wv = mem[ea % MemWords]; pc = nxt;
            end
            OP_SW: begin
              ea = va + imm;
              a  = ea % MemWords;
              mem[a] = vb;
              r.mwe = 1'b1;
              r.mwa = AddrW'(a);
              r.mwd = vb;
              pc = nxt;
            end
            OP_JEQ: pc = (va == vb) ? pc + imm + 16'd1 : nxt;
            default: begin  // slti, unsigned against the extended immediate
              wr = 1; wi = rb; wv = (va < imm) ? 16'd1 : 16'd0; pc = nxt;
            end
          endcase
          if (wr && wi != 3'd0) begin
            regs[wi] = wv;
            r.rwe = 1'b1;
            r.rwi = wi;
            r.rwv = wv;
          end
        end
      end
      r.pc     = pc;
      r.halted = halt;
      report_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [DataW-1:0] exp_v, logic [DataW-1:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_report(result_t got);
      result_t e;
      if (report_q.size() == 0) begin
        $error("report with no request outstanding (pc %0h)", got.pc);
        errors++;
        return;
      end
      e = report_q.pop_front();
      n_checked++;
      cmp_field("prog_counter", e.pc, got.pc);
      cmp_field("halted", DataW'(e.halted), DataW'(got.halted));
      cmp_field("reg_wr_en", DataW'(e.rwe), DataW'(got.rwe));
      cmp_field("reg_wr_index", DataW'(e.rwi), DataW'(got.rwi));
      cmp_field("reg_wr_value", e.rwv, got.rwv);
      cmp_field("mem_wr_en", DataW'(e.mwe), DataW'(got.mwe));
      cmp_field("mem_wr_addr", DataW'(e.mwa), DataW'(got.mwa));
      cmp_field("mem_wr_data", e.mwd, got.mwd);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and signals
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                req_type_i;
  logic [AddrW-1:0]    load_addr_i;
  logic [DataW-1:0]    load_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [DataW-1:0]    prog_counter_o;
  logic                halted_o;
  logic                reg_wr_en_o;
  logic [RegIdxW-1:0]  reg_wr_index_o;
  logic [DataW-1:0]    reg_wr_value_o;
  logic                mem_wr_en_o;
  logic [AddrW-1:0]    mem_wr_addr_o;
  logic [DataW-1:0]    mem_wr_data_o;

  core_scoreboard sb = new();

  int n_sent         = 0;
  int n_recv         = 0;
  bit send_quiet     = 1'b0;  // stretches with no sender gaps
  bit recv_quiet     = 1'b0;  // stretches with no receiver stalls
  bit long_hold_done = 1'b0;
  bit drain_done     = 1'b0;

  always #2 clk_i = ~clk_i;

  sixteen_bit_risc_core_step_core #(
    .MEM_WORDS(MemWords)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .load_addr_i   (load_addr_i),
    .load_data_i   (load_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .prog_counter_o(prog_counter_o),
    .halted_o      (halted_o),
    .reg_wr_en_o   (reg_wr_en_o),
    .reg_wr_index_o(reg_wr_index_o),
    .reg_wr_value_o(reg_wr_value_o),
    .mem_wr_en_o   (mem_wr_en_o),
    .mem_wr_addr_o (mem_wr_addr_o),
    .mem_wr_data_o (mem_wr_data_o)
  );

  // --------------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(req_type_i, load_addr_i, load_data_i);
      if (out_valid_o && out_ready_i) begin
        got.pc     = prog_counter_o;
        got.halted = halted_o;
        got.rwe    = reg_wr_en_o;
        got.rwi    = reg_wr_index_o;
        got.rwv    = reg_wr_value_o;
        got.mwe    = mem_wr_en_o;
        got.mwa    = mem_wr_addr_o;
        got.mwd    = mem_wr_data_o;
        sb.check_report(got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Instruction helpers
  // --------------------------------------------------------------------------
  function automatic logic [DataW-1:0] enc_rrr(logic [3:0] fn, logic [2:0] ra, logic [2:0] rb,
                                               logic [2:0] rc);
    return {OP_ALU, ra, rb, rc, fn};
  endfunction

  function automatic logic [DataW-1:0] enc_ri(opcode_e op, logic [2:0] ra, logic [2:0] rb,
                                              logic [6:0] imm);
    return {op, ra, rb, imm};
  endfunction

  // A j whose target equals the full pc would stop the core for good.
  function automatic bit stops_core(logic [DataW-1:0] w, logic [DataW-1:0] at_pc);
    return (opcode_e'(w[15:13]) == OP_J) && ({3'b000, w[12:0]} == at_pc);
  endfunction

  // Random instruction that is safe to run at at_pc (never a halting jump).
  function automatic logic [DataW-1:0] rand_insn(logic [DataW-1:0] at_pc);
    logic [3:0]       listed [6];
    opcode_e          op;
    logic [3:0]       fn;
    logic [AddrW-1:0] tgt;
    logic [DataW-1:0] w;
    listed = '{FnAdd, FnSub, FnOr, FnAnd, FnSlt, FnJr};
    op = opcode_e'($urandom_range(0, 7));
    case (op)
      OP_ALU: begin
        fn = ($urandom_range(0, 9) < 8) ? listed[$urandom_range(0, 5)] : 4'($urandom);
        w  = enc_rrr(fn, 3'($urandom), 3'($urandom), 3'($urandom));
      end
      OP_J, OP_JAL: begin
        // half the jumps land near the current pc, the rest anywhere
        tgt = $urandom_range(0, 1) ? AddrW'(at_pc + 16'($urandom_range(0, 15)))
                                   : AddrW'($urandom);
        if ({3'b000, tgt} == at_pc) tgt = tgt ^ 13'd1;
        w = {op, tgt};
      end
      default: w = enc_ri(op, 3'($urandom), 3'($urandom), 7'($urandom));
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver; called at a falling edge, returns at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_request(input bit rtype, input logic [AddrW-1:0] laddr,
                              input logic [DataW-1:0] ldata);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= rtype;
    load_addr_i <= laddr;
    load_data_i <= ldata;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    n_sent++;
    if (n_sent % 100 == 0) send_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Writes w at the word the pc points to, then executes it.
  task automatic run_insn(input logic [DataW-1:0] w);
    send_request(1'b0, AddrW'(sb.pc % MemWords), w);
    send_request(1'b1, AddrW'($urandom), 16'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off to back the core up
  // --------------------------------------------------------------------------
  initial begin : receiver
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!long_hold_done && sb.n_checked >= HoldAt) begin
        long_hold_done = 1'b1;
        gap = HoldCycles;
      end else begin
        gap = recv_quiet ? 0 : $urandom_range(0, 5);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
      n_recv++;
      if (n_recv % 64 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int               sel;
    int               target;
    logic [DataW-1:0] cur;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = 1'b0;
    load_addr_i = '0;
    load_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed program: immediates at both ends, add and sub, a discarded
    // write to r0, slti against a negative immediate, store and load through a
    // wrapped address, an unknown function, a taken jeq, jal and jr out to a
    // pc past the memory size, then a j that matches the pc only modulo memory.
    run_insn(enc_ri(OP_ADDI, 3'd0, 3'd1, 7'h7F));        // r1 = -1
    run_insn(enc_ri(OP_ADDI, 3'd0, 3'd2, 7'h3F));        // r2 = 63
    run_insn(enc_rrr(FnAdd, 3'd1, 3'd2, 3'd3));
    run_insn(enc_rrr(FnSub, 3'd2, 3'd1, 3'd4));
    run_insn(enc_ri(OP_ADDI, 3'd1, 3'd0, 7'h05));        // to r0, dropped
    run_insn(enc_ri(OP_SLTI, 3'd2, 3'd3, 7'h40));
    run_insn(enc_ri(OP_SW, 3'd0, 3'd1, 7'h7F));          // 0 - 1 wraps to top word
    run_insn(enc_ri(OP_LW, 3'd0, 3'd4, 7'h7F));
    run_insn(enc_rrr(4'hF, 3'd1, 3'd2, 3'd5));           // unknown: pc stays
    run_insn(enc_ri(OP_JEQ, 3'd0, 3'd0, 7'h02));
    run_insn({OP_JAL, 13'h1FFF});
    run_insn(enc_rrr(FnJr, 3'd1, 3'd0, 3'd0));           // pc = 0xFFFF
    run_insn({OP_J, 13'h1FFF});                          // no halt: pc is 16 bits

    // Random part: mostly freshly written instructions, some re-runs of what
    // memory already holds, and stray loads anywhere.
    target = n_sent + RandomReqs;
    while (n_sent < target) begin
      if (!drain_done && n_sent >= PauseAt) begin
        drain_done = 1'b1;
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (sb.pending() != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        run_insn(rand_insn(sb.pc));
      end else if (sel < 85) begin
        cur = sb.mem[sb.pc % MemWords];
        if (stops_core(cur, sb.pc)) run_insn(rand_insn(sb.pc));
        else send_request(1'b1, AddrW'($urandom), 16'($urandom));
      end else begin
        send_request(1'b0, AddrW'($urandom), 16'($urandom));
      end
    end

    // Halt: back to zero, j to self, then requests while halted.
    run_insn(enc_rrr(FnJr, 3'd0, 3'd0, 3'd0));
    run_insn({OP_J, 13'd0});
    send_request(1'b1, '0, '0);
    send_request(1'b0, AddrW'($urandom), 16'($urandom));
    send_request(1'b1, '1, '1);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d requests (%0d loads, %0d steps); %0d reports checked, core halted: %0d.",
             n_sent, sb.n_loads, sb.n_steps, sb.n_checked, sb.halt);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run including the memory sweep.
  initial begin : watchdog
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sixteen_bit_risc_core_step_core.f =====
rtl/sbrc_pkg.sv
rtl/sbrc_mem.sv
rtl/sbrc_rf.sv
rtl/sixteen_bit_risc_core_step_core.sv
sim/sixteen_bit_risc_core_step_core_tb.sv
